// File: src/ppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the pulse pair decoder: register map,
// classified pair commands, result record and tolerance arithmetic.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // Code register width (8..64)
  localparam int CODE_WIDTH = 64;
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = 4;

  // Register reset values
  localparam logic [15:0] SHORT_TIME_RST = 16'd230;
  localparam logic [15:0] LONG_TIME_RST  = 16'd1550;
  localparam logic [6:0]  TOL_PCT_RST    = 7'd20;
  localparam logic [6:0]  FRAME_BITS_RST = 7'd18;

  // Tolerance = max(TOL_FLOOR, short_time * percent / 100).
  // The divide by 100 is a multiply by ceil(2^30 / 100) and a shift; exact for
  // every product of a 16-bit time and a 7-bit percent.
  localparam int          TOL_W     = 17;
  localparam int          PROD_W    = 23;
  localparam int          RECIP_W   = 24;
  localparam int          TOL_SHIFT = 30;
  localparam logic [RECIP_W-1:0] TOL_RECIP = 24'd10737419;
  localparam logic [TOL_W-1:0]   TOL_FLOOR = 17'd160;

  typedef enum logic [1:0] {
    REG_SHORT_TIME = 2'd0,
    REG_LONG_TIME  = 2'd1,
    REG_TOL_PCT    = 2'd2,
    REG_FRAME_BITS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      short_time;
    logic [15:0]      long_time;
    logic [6:0]       tol_pct;
    logic [CNT_W-1:0] frame_target;  // frame_bits limited to CODE_WIDTH
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_BIT     = 2'd0,  // valid bit, frame goes on
    CMD_BIT_END = 2'd1,  // valid bit followed by a gap, frame ends
    CMD_BAD     = 2'd2   // pair matches nothing, frame ends
  } cmd_kind_t;

  typedef struct packed {
    logic      start;
    logic      last;
    cmd_kind_t kind;
    logic      bit_val;
  } cmd_t;

  typedef struct packed {
    logic [63:0]      decoded_code;
    logic [CNT_W-1:0] bit_count;
    logic             success;
  } res_t;

endpackage
`default_nettype wire

// File: src/pwm_pulse_pair_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_pulse_pair_decoder_core
// Pulse pair width decoder: classifies high/low pairs as 0 or 1 bits,
// collects them into a code and reports one result per frame.
// ----------------------------------------------------------------------------
// Path: the pair that ends a frame passes the front stages, the command queue
//   and the result queue before its result is on the out_ ports.
// Throughput: one pair per cycle while no stall further on raises full; the
//   tolerance multiply and divide are pipelined in the front.
// Reset (rst_n, synchronous): registers take their defaults, both queues
//   empty, and the decoder waits for a pair with frame_start set.
// ----------------------------------------------------------------------------
module pwm_pulse_pair_decoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input pairs
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       in_frame_start,
  input  wire logic [15:0]                in_high_time,
  input  wire logic [15:0]                in_low_time,
  input  wire logic                       in_last_pair,
  // results
  output logic                            empty,
  input  wire logic                       pop,
  output logic [63:0]                     out_decoded_code,
  output logic [ppd_pkg::CNT_W-1:0]       out_bit_count,
  output logic                            out_success,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ppd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import ppd_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in, cmd_out;
  logic cmd_wr, cmd_full, cmd_empty, cmd_take;
  res_t res;

  // Registers: short/long nominal times, tolerance percent, frame length.
  ppd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: accept a pair and classify it into a bit, a bit plus gap, or bad.
  ppd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .in_frame_start (in_frame_start),
    .in_high_time   (in_high_time),
    .in_low_time    (in_low_time),
    .in_last_pair   (in_last_pair),
    .cmd_wr         (cmd_wr),
    .cmd            (cmd_in),
    .cmd_full       (cmd_full)
  );

  // Decouple the classifier from the frame logic so either side can stall.
  ppd_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .q_full  (cmd_full),
    .rd_en   (cmd_take),
    .rd_data (cmd_out),
    .q_empty (cmd_empty)
  );

  // Back: advance the frame state and queue the result when a frame ends.
  ppd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_target (cfg.frame_target),
    .cmd_valid    (!cmd_empty),
    .cmd          (cmd_out),
    .cmd_take     (cmd_take),
    .empty        (empty),
    .pop          (pop),
    .res          (res)
  );

  assign out_decoded_code = res.decoded_code;
  assign out_bit_count    = res.bit_count;
  assign out_success      = res.success;

endmodule
`default_nettype wire

// File: src/ppd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_cfg
// APB register file: timing, tolerance and frame length registers.
// ----------------------------------------------------------------------------
module ppd_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ppd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output ppd_pkg::cfg_t                  cfg
);
  import ppd_pkg::*;

  logic [15:0] short_time_r;
  logic [15:0] long_time_r;
  logic [6:0]  tol_pct_r;
  logic [6:0]  frame_bits_r;
  logic        wr_en;
  cfg_reg_t    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_time_r <= SHORT_TIME_RST;
      long_time_r  <= LONG_TIME_RST;
      tol_pct_r    <= TOL_PCT_RST;
      frame_bits_r <= FRAME_BITS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SHORT_TIME: short_time_r <= pwdata[15:0];
        REG_LONG_TIME:  long_time_r  <= pwdata[15:0];
        REG_TOL_PCT:    tol_pct_r    <= pwdata[6:0];
        REG_FRAME_BITS: frame_bits_r <= pwdata[6:0];
        default:        short_time_r <= short_time_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHORT_TIME: prdata = {16'd0, short_time_r};
      REG_LONG_TIME:  prdata = {16'd0, long_time_r};
      REG_TOL_PCT:    prdata = {25'd0, tol_pct_r};
      REG_FRAME_BITS: prdata = {25'd0, frame_bits_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.short_time   = short_time_r;
  assign cfg.long_time    = long_time_r;
  assign cfg.tol_pct      = tol_pct_r;
  assign cfg.frame_target = (frame_bits_r > CNT_W'(CODE_WIDTH)) ? CNT_W'(CODE_WIDTH)
                                                                 : frame_bits_r;

endmodule
`default_nettype wire

// File: src/ppd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_front
// Accept pulse pairs and classify them: two stages work out the tolerance,
// then the pair is matched against short, long and gap and turned into a cmd.
// ----------------------------------------------------------------------------
module ppd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ppd_pkg::cfg_t cfg,
  input  wire logic          push,
  output logic               full,
  input  wire logic          in_frame_start,
  input  wire logic [15:0]   in_high_time,
  input  wire logic [15:0]   in_low_time,
  input  wire logic          in_last_pair,
  output logic               cmd_wr,
  output ppd_pkg::cmd_t      cmd,
  input  wire logic          cmd_full
);
  import ppd_pkg::*;

  localparam int MUL_W = PROD_W + RECIP_W;

  // stage 1: pair plus short_time * percent
  logic              s1_v_r;
  logic              s1_start_r, s1_last_r;
  logic [15:0]       s1_hi_r, s1_lo_r;
  logic [PROD_W-1:0] s1_prod_r;
  // stage 2: pair plus floored tolerance
  logic              s2_v_r;
  logic              s2_start_r, s2_last_r;
  logic [15:0]       s2_hi_r, s2_lo_r;
  logic [TOL_W-1:0]  s2_tol_r;

  logic              s1_ready, s2_ready, in_take;
  logic [MUL_W-1:0]  tol_mul;
  logic [TOL_W-1:0]  tol_q, tol_nxt;
  logic [15:0]       d_hl, d_hs, d_ll, d_ls;
  logic              hi_long, hi_short, lo_long, lo_short, gap;

  assign s2_ready = !s2_v_r || !cmd_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign full     = !s1_ready;
  assign in_take  = push && s1_ready;

  assign tol_mul = MUL_W'(s1_prod_r) * MUL_W'(TOL_RECIP);
  assign tol_q   = tol_mul[TOL_SHIFT +: TOL_W];
  assign tol_nxt = (tol_q < TOL_FLOOR) ? TOL_FLOOR : tol_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= push;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
    if (in_take) begin
      s1_start_r <= in_frame_start;
      s1_last_r  <= in_last_pair;
      s1_hi_r    <= in_high_time;
      s1_lo_r    <= in_low_time;
      s1_prod_r  <= PROD_W'(cfg.short_time) * PROD_W'(cfg.tol_pct);
    end
    if (s2_ready && s1_v_r) begin
      s2_start_r <= s1_start_r;
      s2_last_r  <= s1_last_r;
      s2_hi_r    <= s1_hi_r;
      s2_lo_r    <= s1_lo_r;
      s2_tol_r   <= tol_nxt;
    end
  end

  // absolute differences against the nominal times
  assign d_hl = (s2_hi_r >= cfg.long_time)  ? s2_hi_r - cfg.long_time  : cfg.long_time  - s2_hi_r;
  assign d_hs = (s2_hi_r >= cfg.short_time) ? s2_hi_r - cfg.short_time : cfg.short_time - s2_hi_r;
  assign d_ll = (s2_lo_r >= cfg.long_time)  ? s2_lo_r - cfg.long_time  : cfg.long_time  - s2_lo_r;
  assign d_ls = (s2_lo_r >= cfg.short_time) ? s2_lo_r - cfg.short_time : cfg.short_time - s2_lo_r;

  assign hi_long  = {1'b0, d_hl} < s2_tol_r;
  assign hi_short = {1'b0, d_hs} < s2_tol_r;
  assign lo_long  = {1'b0, d_ll} < s2_tol_r;
  assign lo_short = {1'b0, d_ls} < s2_tol_r;
  assign gap      = {2'b00, s2_lo_r} > {cfg.long_time, 2'b00};

  always_comb begin
    cmd.start   = s2_start_r;
    cmd.last    = s2_last_r;
    cmd.kind    = CMD_BAD;
    cmd.bit_val = 1'b0;
    if (hi_long && lo_short) begin
      cmd.kind    = CMD_BIT;
      cmd.bit_val = 1'b1;
    end else if (hi_short && lo_long) begin
      cmd.kind    = CMD_BIT;
    end else if (hi_short && gap) begin
      cmd.kind    = CMD_BIT_END;
    end else if (hi_long && gap) begin
      cmd.kind    = CMD_BIT_END;
      cmd.bit_val = 1'b1;
    end
  end

  assign cmd_wr = s2_v_r && !cmd_full;

endmodule
`default_nettype wire

// File: src/ppd_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_cmd_queue
// Two-entry queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module ppd_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire ppd_pkg::cmd_t wr_data,
  output logic               q_full,
  input  wire logic          rd_en,
  output ppd_pkg::cmd_t      rd_data,
  output logic               q_empty
);
  import ppd_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      if (do_wr && !do_rd)      cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

// File: src/ppd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_back
// Frame state: shift bits into the code register, end frames and queue one
// result per frame in a two-entry output queue.
// ----------------------------------------------------------------------------
module ppd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [ppd_pkg::CNT_W-1:0] frame_target,
  input  wire logic                      cmd_valid,
  input  wire ppd_pkg::cmd_t             cmd,
  output logic                           cmd_take,
  output logic                           empty,
  input  wire logic                      pop,
  output ppd_pkg::res_t                  res
);
  import ppd_pkg::*;

  logic [CODE_WIDTH-1:0] code_r, code_nxt;
  logic [CNT_W-1:0]      bits_r, bits_nxt;
  logic                  done_r, done_nxt;
  logic                  emit;
  res_t                  res_nxt;

  res_t       out_mem_r [2];
  logic       out_wr_ptr_r, out_rd_ptr_r;
  logic [1:0] out_cnt_r;
  logic       out_full, out_wr, out_rd;

  assign out_full = (out_cnt_r == 2'd2);
  assign cmd_take = cmd_valid && !out_full;

  always_comb begin
    code_nxt = code_r;
    bits_nxt = bits_r;
    done_nxt = done_r;
    emit     = 1'b0;
    if (cmd.start) begin
      code_nxt = '0;
      bits_nxt = '0;
      done_nxt = 1'b0;
    end
    if (!done_nxt) begin
      if (bits_nxt >= frame_target) begin
        emit = 1'b1;
      end else begin
        unique case (cmd.kind)
          CMD_BIT: begin
            code_nxt = {code_nxt[CODE_WIDTH-2:0], cmd.bit_val};
            bits_nxt = bits_nxt + CNT_W'(1);
          end
          CMD_BIT_END: begin
            code_nxt = {code_nxt[CODE_WIDTH-2:0], cmd.bit_val};
            bits_nxt = bits_nxt + CNT_W'(1);
            emit     = 1'b1;
          end
          default: emit = 1'b1;
        endcase
        if (bits_nxt >= frame_target || cmd.last) emit = 1'b1;
      end
    end
    if (emit) done_nxt = 1'b1;
    res_nxt.success      = (bits_nxt >= frame_target);
    res_nxt.bit_count    = bits_nxt;
    res_nxt.decoded_code = res_nxt.success ? 64'(code_nxt) : 64'd0;
  end

  assign out_wr = cmd_take && emit;
  assign out_rd = pop && !empty;
  assign empty  = (out_cnt_r == 2'd0);
  assign res    = out_mem_r[out_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r       <= '0;
      bits_r       <= '0;
      done_r       <= 1'b1;
      out_wr_ptr_r <= 1'b0;
      out_rd_ptr_r <= 1'b0;
      out_cnt_r    <= 2'd0;
    end else begin
      if (cmd_take) begin
        code_r <= code_nxt;
        bits_r <= bits_nxt;
        done_r <= done_nxt;
      end
      if (out_wr) out_wr_ptr_r <= !out_wr_ptr_r;
      if (out_rd) out_rd_ptr_r <= !out_rd_ptr_r;
      if (out_wr && !out_rd)      out_cnt_r <= out_cnt_r + 2'd1;
      else if (out_rd && !out_wr) out_cnt_r <= out_cnt_r - 2'd1;
    end
    if (out_wr) out_mem_r[out_wr_ptr_r] <= res_nxt;
  end

  a_out_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_fail_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !res.success) |-> (res.decoded_code == 64'd0))
    else $error("failed frame carries a nonzero code");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= CNT_W'(CODE_WIDTH))
    else $error("bit count beyond code width");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |=> done_r)
    else $error("frame still open after its result");

endmodule
`default_nettype wire

// File: bench/pulse_pair_frame_checker.sv
// ----------------------------------------------------------------------------
// pulse_pair_frame_checker
// Watches the pair, result and register ports of the pulse pair decoder,
// works out the frame result that each accepted pair produces and compares
// every popped result against the oldest one still owed.
// ----------------------------------------------------------------------------
module pulse_pair_frame_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       full,
  input  logic                       in_frame_start,
  input  logic [15:0]                in_high_time,
  input  logic [15:0]                in_low_time,
  input  logic                       in_last_pair,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [63:0]                out_decoded_code,
  input  logic [ppd_pkg::CNT_W-1:0]  out_bit_count,
  input  logic                       out_success,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         pending,
  output int                         results_seen
);
  import ppd_pkg::*;

  localparam int GAP_FACTOR = 4;
  localparam int PERCENT    = 100;
  localparam int PRINT_CAP  = 40;

  // register copies
  logic [15:0] reg_short;
  logic [15:0] reg_long;
  logic [6:0]  reg_tol_pct;
  logic [6:0]  reg_frame_bits;

  // frame state
  logic [63:0]      code_acc;
  logic [CNT_W-1:0] bits_acc;
  logic             awaiting_start;

  res_t expected_frames[$];
  res_t fresh;
  res_t want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    if (mismatches < PRINT_CAP)
      $display("%0t: %s: got %0h, wanted %0h", $time, what, got, wanted);
    mismatches = mismatches + 1;
  endtask

  function automatic logic near_nominal(input logic [15:0] value, nominal,
                                        input logic [31:0] tol);
    int d;
    d = int'(value) - int'(nominal);
    if (d < 0) d = -d;
    return 32'(d) < tol;
  endfunction

  // Advance the frame by one pair; return 1 when the pair closes the frame.
  function automatic logic decode_pair(input logic start, input logic [15:0] hi,
                                       input logic [15:0] lo, input logic last,
                                       output res_t frame_res);
    logic [31:0] tol;
    logic [31:0] target;
    logic        hl, hs, ll, ls, gap, ends, ok, one;
    cmd_kind_t   kind;
    tol    = (32'(reg_short) * 32'(reg_tol_pct)) / PERCENT;
    target = (reg_frame_bits > CODE_WIDTH) ? CODE_WIDTH : 32'(reg_frame_bits);
    frame_res = '0;
    if (tol < 32'(TOL_FLOOR)) tol = 32'(TOL_FLOOR);
    if (start) begin
      code_acc       = '0;
      bits_acc       = '0;
      awaiting_start = 1'b0;
    end
    if (awaiting_start) return 1'b0;

    if (32'(bits_acc) >= target) begin
      // target already met: close without looking at the pair
      ends = 1'b1;
    end else begin
      hl  = near_nominal(hi, reg_long, tol);
      hs  = near_nominal(hi, reg_short, tol);
      ll  = near_nominal(lo, reg_long, tol);
      ls  = near_nominal(lo, reg_short, tol);
      gap = 32'(lo) > 32'(reg_long) * GAP_FACTOR;
      one = 1'b0;
      if (hl && ls) begin
        kind = CMD_BIT;
        one  = 1'b1;
      end else if (hs && ll) begin
        kind = CMD_BIT;
      end else if (hs && gap) begin
        kind = CMD_BIT_END;
      end else if (hl && gap) begin
        kind = CMD_BIT_END;
        one  = 1'b1;
      end else begin
        kind = CMD_BAD;
      end
      if (kind != CMD_BAD) begin
        code_acc = {code_acc[62:0], one};
        bits_acc = bits_acc + 1'b1;
      end
      ends = (kind != CMD_BIT) || (32'(bits_acc) >= target) || last;
    end

    if (ends) begin
      ok = 32'(bits_acc) >= target;
      frame_res.decoded_code = ok ? (code_acc & ({64{1'b1}} >> (64 - CODE_WIDTH))) : '0;
      frame_res.bit_count    = bits_acc;
      frame_res.success      = ok;
      awaiting_start         = 1'b1;
    end
    return ends;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_short      = SHORT_TIME_RST;
      reg_long       = LONG_TIME_RST;
      reg_tol_pct    = TOL_PCT_RST;
      reg_frame_bits = FRAME_BITS_RST;
      code_acc       = '0;
      bits_acc       = '0;
      awaiting_start = 1'b1;
      expected_frames.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_SHORT_TIME: reg_short      = pwdata[15:0];
          REG_LONG_TIME:  reg_long       = pwdata[15:0];
          REG_TOL_PCT:    reg_tol_pct    = pwdata[6:0];
          REG_FRAME_BITS: reg_frame_bits = pwdata[6:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (decode_pair(in_frame_start, in_high_time, in_low_time, in_last_pair, fresh))
          expected_frames.push_back(fresh);
      end
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_frames.size() == 0) begin
          report_mismatch("result with no frame pending", out_decoded_code, '0);
        end else begin
          want = expected_frames.pop_front();
          if (out_decoded_code !== want.decoded_code)
            report_mismatch("decoded_code", out_decoded_code, want.decoded_code);
          if (out_bit_count !== want.bit_count)
            report_mismatch("bit_count", 64'(out_bit_count), 64'(want.bit_count));
          if (out_success !== want.success)
            report_mismatch("success", 64'(out_success), 64'(want.success));
        end
      end
      pending <= expected_frames.size();
    end
  end

endmodule

// File: bench/pwm_pulse_pair_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// pwm_pulse_pair_decoder_core_tb
// Drives pulse pairs and register writes into the decoder, pops results with
// random stalls and leaves the comparison to the frame checker beside it.
// Runs a directed set of frames first, then a long hold-off to fill the
// block, then random frames over a series of register settings.
// ----------------------------------------------------------------------------
module pwm_pulse_pair_decoder_core_tb;
  import ppd_pkg::*;

  localparam int ITEM_GOAL      = 550;
  localparam int PHASE_ITEMS    = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {FRAME_LAST, FRAME_OPEN, FRAME_GAP, FRAME_BROKEN} frame_style_t;

  logic clk;
  logic rst_n = 1'b0;

  // pair request channel
  logic        push           = 1'b0;
  logic        full;
  logic        in_frame_start = 1'b0;
  logic [15:0] in_high_time   = '0;
  logic [15:0] in_low_time    = '0;
  logic        in_last_pair   = 1'b0;

  // result channel
  logic             empty;
  logic             pop = 1'b0;
  logic [63:0]      out_decoded_code;
  logic [CNT_W-1:0] out_bit_count;
  logic             out_success;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int pending;
  int results_seen;

  // stimulus-side view of the current setting, used to shape pairs
  int cur_short;
  int cur_long;
  int cur_tol;
  int cur_bits;
  int items_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // hold-off handshake between stimulus and the pop process
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  pwm_pulse_pair_decoder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_frame_start   (in_frame_start),
    .in_high_time     (in_high_time),
    .in_low_time      (in_low_time),
    .in_last_pair     (in_last_pair),
    .empty            (empty),
    .pop              (pop),
    .out_decoded_code (out_decoded_code),
    .out_bit_count    (out_bit_count),
    .out_success      (out_success),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  pulse_pair_frame_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_frame_start   (in_frame_start),
    .in_high_time     (in_high_time),
    .in_low_time      (in_low_time),
    .in_last_pair     (in_last_pair),
    .empty            (empty),
    .pop              (pop),
    .out_decoded_code (out_decoded_code),
    .out_bit_count    (out_bit_count),
    .out_success      (out_success),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pop side: stall at the phase's rate, or hold pop low for a long
  // stretch whenever the stimulus asks for a hold-off.
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one pair request, idling first at the phase's rate; return at the
  // edge that accepts it, with push still high.
  task automatic send_pair(input logic start, input logic [15:0] hi,
                           input logic [15:0] lo, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_frame_start <= start;
    in_high_time   <= hi;
    in_low_time    <= lo;
    in_last_pair   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // Drop push and wait until every owed result has been popped, then let
  // pairs that produce no result clear the pipeline.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle and access cycle, then the port is released.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_setting(input int short_v, input int long_v,
                                 input int pct, input int bits);
    settle();
    write_reg(REG_SHORT_TIME, short_v);
    write_reg(REG_LONG_TIME, long_v);
    write_reg(REG_TOL_PCT, pct);
    write_reg(REG_FRAME_BITS, bits);
    cur_short = short_v;
    cur_long  = long_v;
    cur_bits  = bits;
    cur_tol   = short_v * pct / 100;
    if (cur_tol < int'(TOL_FLOOR)) cur_tol = int'(TOL_FLOOR);
  endtask

  // Duration around a nominal: mostly inside the tolerance, now and then
  // exactly on its edge, which must not match.
  function automatic logic [15:0] near(input int nominal);
    int off;
    int v;
    if ($urandom_range(15) == 0) off = $urandom_range(1) ? cur_tol : -cur_tol;
    else off = int'($urandom_range(0, 2 * cur_tol - 2)) - (cur_tol - 1);
    v = nominal + off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // One frame with random bits; the style picks how it ends or breaks one pair.
  task automatic send_frame(input int nbits, input frame_style_t style);
    int          brk;
    int          g;
    logic        one;
    logic        fin;
    logic [15:0] hi;
    logic [15:0] lo;
    brk = $urandom_range(0, nbits - 1);
    for (int i = 0; i < nbits; i++) begin
      one = $urandom_range(1);
      hi  = near(one ? cur_long : cur_short);
      lo  = near(one ? cur_short : cur_long);
      fin = (i == nbits - 1);
      if (style == FRAME_GAP && fin) begin
        g  = 4 * cur_long + 1 + $urandom_range(0, 3000);
        lo = (g > 65535) ? 16'hFFFF : 16'(g);
      end
      if (style == FRAME_BROKEN && i == brk) begin
        hi = 16'($urandom);
        lo = 16'($urandom);
      end
      send_pair(i == 0, hi, lo, fin && style == FRAME_LAST);
    end
  endtask

  initial begin : stimulus
    int phase;
    int base;
    int tgt;
    int s;

    cur_short = SHORT_TIME_RST;
    cur_long  = LONG_TIME_RST;
    cur_tol   = int'(TOL_FLOOR);
    cur_bits  = FRAME_BITS_RST;

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset register values ---
    // pair before any start: ignored
    send_pair(1'b0, 16'd1550, 16'd230, 1'b0);
    // two bits, then a bit right inside the tolerance with last set
    send_pair(1'b1, 16'd1550, 16'd230, 1'b0);
    send_pair(1'b0, 16'd230, 16'd1550, 1'b0);
    send_pair(1'b0, 16'd1709, 16'd71, 1'b1);
    // field extremes: both pairs match nothing
    send_pair(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(1'b1, 16'h0000, 16'h0000, 1'b1);
    // a zero bit, then a one bit followed by a gap
    send_pair(1'b1, 16'd230, 16'd1550, 1'b0);
    send_pair(1'b0, 16'd1550, 16'hFFFF, 1'b0);
    // restart in mid-frame drops the open frame
    send_pair(1'b1, 16'd1550, 16'd230, 1'b0);
    send_pair(1'b1, 16'd230, 16'd1550, 1'b0);
    send_pair(1'b1, 16'd230, 16'd1550, 1'b1);
    // high exactly on the tolerance edge: invalid
    send_pair(1'b1, 16'd1710, 16'd230, 1'b1);
    // after the frame closed: ignored
    send_pair(1'b0, 16'd1550, 16'd230, 1'b1);

    // complete short code
    program_setting(230, 1550, 20, 3);
    send_pair(1'b1, 16'd1550, 16'd230, 1'b0);
    send_pair(1'b0, 16'd230, 16'd1550, 1'b0);
    send_pair(1'b0, 16'd1550, 16'd230, 1'b0);

    // leave a frame open, lower the target under it: next pair closes it
    send_pair(1'b1, 16'd230, 16'd1550, 1'b0);
    send_pair(1'b0, 16'd1550, 16'd230, 1'b0);
    program_setting(230, 1550, 20, 1);
    send_pair(1'b0, 16'h0000, 16'h0000, 1'b0);

    // zero target: every start closes at once
    program_setting(230, 1550, 20, 0);
    send_pair(1'b1, 16'h0000, 16'hFFFF, 1'b0);

    // --- pressure: one result per request while the pop side holds off ---
    program_setting(230, 1550, 20, 1);
    hold_req <= hold_req + 1;
    repeat (48) send_frame(1, FRAME_OPEN);

    // --- random frames over a series of settings and idling phases ---
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase)
        1: program_setting(300, 1200, 100, 64);
        2: program_setting(500, 2500, 127, 127);
        3: program_setting(0, 65535, 0, 5);
        5: program_setting(65535, 0, 100, 2);
        default: begin
          s = $urandom_range(100, 2000);
          program_setting(s, (s * $urandom_range(3, 8) > 16000) ? 16000 :
                          s * $urandom_range(3, 8), $urandom_range(0, 100),
                          ($urandom_range(3) == 0) ? $urandom_range(11, 40) :
                          $urandom_range(1, 10));
        end
      endcase
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 75; end
        default: begin tx_idle_pct = 9; rx_stall_pct <= 9; end
      endcase
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          // noise: any field values at all
          send_pair($urandom_range(1), 16'($urandom), 16'($urandom), $urandom_range(1));
        end else begin
          tgt = (cur_bits > CODE_WIDTH) ? CODE_WIDTH : cur_bits;
          send_frame($urandom_range(1, tgt + 1), frame_style_t'($urandom_range(3)));
        end
      end
      phase = phase + 1;
    end

    // Drain and give the verdict.
    settle();
    if (mismatches == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
src/ppd_pkg.sv
src/ppd_cfg.sv
src/ppd_front.sv
src/ppd_cmd_queue.sv
src/ppd_back.sv
src/pwm_pulse_pair_decoder_core.sv
bench/pulse_pair_frame_checker.sv
bench/pwm_pulse_pair_decoder_core_tb.sv
